>>> design/dpbp_pkg.sv
// ----------------------------------------------------------------------------
// Depth pixel back-projection package
// Request and result payload types, register indexes and field widths.
// ----------------------------------------------------------------------------
package dpbp_pkg;

	localparam int COORD_W    = 12;
	localparam int DEPTH_W    = 16;
	localparam int COLOUR_W   = 8;
	localparam int RECIP_W    = 24;
	localparam int CENTRE_W   = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int POS_W      = 48;
	localparam int Z_W        = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INV_DEPTH_SCALE = 3'd0,
		REG_CENTER_X        = 3'd1,
		REG_CENTER_Y        = 3'd2,
		REG_INV_FOCAL_X     = 3'd3,
		REG_INV_FOCAL_Y     = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [COORD_W-1:0]  col;
		logic [COORD_W-1:0]  row;
		logic [DEPTH_W-1:0]  depth;
		logic [COLOUR_W-1:0] blue;
		logic [COLOUR_W-1:0] green;
		logic [COLOUR_W-1:0] red;
	} pixel_t;

	typedef struct packed {
		logic signed [POS_W-1:0] point_x;
		logic signed [POS_W-1:0] point_y;
		logic [Z_W-1:0]          point_z;
		logic [COLOUR_W-1:0]     out_blue;
		logic [COLOUR_W-1:0]     out_green;
		logic [COLOUR_W-1:0]     out_red;
	} point_t;

	typedef struct packed {
		logic [COLOUR_W-1:0] blue;
		logic [COLOUR_W-1:0] green;
		logic [COLOUR_W-1:0] red;
	} colour_t;

endpackage

>>> design/depth_pixel_backprojection_unit.sv
// ----------------------------------------------------------------------------
// Depth pixel back-projection unit
// Back-projects a depth pixel through a pinhole camera into a coloured 3-D
// point; pixels with zero depth give no point.
//
//   channel   signals                              direction  handshake
//   request   start, busy, pixel                   in         start & !busy
//   result    result_valid, point                  out        one-cycle strobe
//   config    cfg_valid, cfg_ready, cfg_index,     in         valid & ready
//             cfg_data
//
// One request per cycle; each point passes through the stages of the chain:
// the depth product, range product and the split reciprocal products,
// each in a stage of its own, then sum and sign stages.
// busy and cfg_ready stay low and high; the result side has no back-pressure.
// Reset clears the stage valid bits and loads the default camera registers.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  dpbp_pkg::pixel_t              pixel,
	output logic                          result_valid,
	output dpbp_pkg::point_t              point,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dpbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dpbp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dpbp_pkg::*;

	logic [RECIP_W-1:0]  inv_depth_scale_q;
	logic [CENTRE_W-1:0] center_x_q;
	logic [CENTRE_W-1:0] center_y_q;
	logic [RECIP_W-1:0]  inv_focal_x_q;
	logic [RECIP_W-1:0]  inv_focal_y_q;

	logic accept;

	logic [CENTRE_W-1:0] pos_x, pos_y;
	logic                neg_x, neg_y;

	logic                          valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [DEPTH_W+RECIP_W-1:0]    zprod_s1;
	logic [CENTRE_W-1:0]           mag_x_s1, mag_y_s1;
	logic                          neg_x_s1, neg_y_s1, neg_x_s2, neg_y_s2;
	logic                          neg_x_s3, neg_y_s3, neg_x_s4, neg_y_s4;
	colour_t                       colour_s1, colour_s2, colour_s3, colour_s4;
	logic [Z_W-1:0]                z_s2, z_s3, z_s4;
	logic [CENTRE_W+Z_W-1:0]       a_x_s2, a_y_s2;
	logic [CENTRE_W+RECIP_W-1:0]   hp_x_s3, hp_y_s3;
	logic [Z_W+RECIP_W-1:0]        lp_x_s3, lp_y_s3;
	logic [POS_W-1:0]              q_x_s4, q_y_s4;
	logic                          rem_x_s4, rem_y_s4;
	point_t                        point_s5;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_depth_scale_q <= RECIP_W'(16777);
			center_x_q        <= CENTRE_W'(5120);
			center_y_q        <= CENTRE_W'(3840);
			inv_focal_x_q     <= RECIP_W'(31957);
			inv_focal_y_q     <= RECIP_W'(31957);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_INV_DEPTH_SCALE: inv_depth_scale_q <= cfg_data[RECIP_W-1:0];
				REG_CENTER_X:        center_x_q        <= cfg_data[CENTRE_W-1:0];
				REG_CENTER_Y:        center_y_q        <= cfg_data[CENTRE_W-1:0];
				REG_INV_FOCAL_X:     inv_focal_x_q     <= cfg_data[RECIP_W-1:0];
				REG_INV_FOCAL_Y:     inv_focal_y_q     <= cfg_data[RECIP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		pos_x = {pixel.col, 4'b0000};
		pos_y = {pixel.row, 4'b0000};
		neg_x = pos_x < center_x_q;
		neg_y = pos_y < center_y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= accept && (pixel.depth != '0);
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		// offsets from the principal point, depth times scale
		zprod_s1  <= pixel.depth * inv_depth_scale_q;
		mag_x_s1  <= neg_x ? (center_x_q - pos_x) : (pos_x - center_x_q);
		mag_y_s1  <= neg_y ? (center_y_q - pos_y) : (pos_y - center_y_q);
		neg_x_s1  <= neg_x;
		neg_y_s1  <= neg_y;
		colour_s1 <= '{blue: pixel.blue, green: pixel.green, red: pixel.red};

		// range times offset
		z_s2      <= zprod_s1[DEPTH_W+RECIP_W-1:8];
		a_x_s2    <= mag_x_s1 * zprod_s1[DEPTH_W+RECIP_W-1:8];
		a_y_s2    <= mag_y_s1 * zprod_s1[DEPTH_W+RECIP_W-1:8];
		neg_x_s2  <= neg_x_s1;
		neg_y_s2  <= neg_y_s1;
		colour_s2 <= colour_s1;

		// split reciprocal products
		hp_x_s3   <= a_x_s2[CENTRE_W+Z_W-1:Z_W] * inv_focal_x_q;
		hp_y_s3   <= a_y_s2[CENTRE_W+Z_W-1:Z_W] * inv_focal_y_q;
		lp_x_s3   <= a_x_s2[Z_W-1:0] * inv_focal_x_q;
		lp_y_s3   <= a_y_s2[Z_W-1:0] * inv_focal_y_q;
		z_s3      <= z_s2;
		neg_x_s3  <= neg_x_s2;
		neg_y_s3  <= neg_y_s2;
		colour_s3 <= colour_s2;

		// recombine, note discarded fraction for floor
		q_x_s4    <= POS_W'({hp_x_s3, 4'b0000}) + POS_W'(lp_x_s3[Z_W+RECIP_W-1:28]);
		q_y_s4    <= POS_W'({hp_y_s3, 4'b0000}) + POS_W'(lp_y_s3[Z_W+RECIP_W-1:28]);
		rem_x_s4  <= lp_x_s3[27:0] != '0;
		rem_y_s4  <= lp_y_s3[27:0] != '0;
		z_s4      <= z_s3;
		neg_x_s4  <= neg_x_s3;
		neg_y_s4  <= neg_y_s3;
		colour_s4 <= colour_s3;

		// apply sign, rounding towards minus infinity
		point_s5.point_x   <= neg_x_s4 ? (~q_x_s4 + POS_W'(!rem_x_s4)) : q_x_s4;
		point_s5.point_y   <= neg_y_s4 ? (~q_y_s4 + POS_W'(!rem_y_s4)) : q_y_s4;
		point_s5.point_z   <= z_s4;
		point_s5.out_blue  <= colour_s4.blue;
		point_s5.out_green <= colour_s4.green;
		point_s5.out_red   <= colour_s4.red;
	end

	assign result_valid = valid_s5;
	assign point        = point_s5;

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && (pixel.depth == '0) |=> !valid_s1)
		else $error("zero-depth request entered the pipeline");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(accept && (pixel.depth != '0), 5))
		else $error("result without a matching request");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && !neg_x_s4 && !neg_y_s4 |=> !point.point_x[POS_W-1] && !point.point_y[POS_W-1])
		else $error("non-negative offset gave a negative coordinate");

	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && (cfg_index == REG_CENTER_X)
			|=> center_x_q == $past(cfg_data[CENTRE_W-1:0]))
		else $error("centre column register not updated");

endmodule
